>>> hw/rtl/heat_equation_1d_stepper_assert.svh
// ----------------------------------------------------------------------------
// Heat equation stepper assertion macros
// Shared property forms for the stepper's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef HEAT_EQUATION_1D_STEPPER_ASSERT_SVH
`define HEAT_EQUATION_1D_STEPPER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HE1D_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("he1d check failed");

// next-cycle implication, disabled during reset
`define HE1D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("he1d check failed");

`endif

>>> hw/rtl/he1d_pkg.sv
// ----------------------------------------------------------------------------
// he1d_pkg
// Types and constants of the 1-D heat equation stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package he1d_pkg;

    localparam int MAX_POINTS      = 64;
    localparam int ADDR_W          = $clog2(MAX_POINTS);
    localparam int CNT_W           = $clog2(MAX_POINTS + 1);
    localparam int MIN_STEP_POINTS = 3;

    localparam int SAMPLE_W   = 24;
    localparam int IDX_W      = 6;
    localparam int COEF_W     = 16;
    localparam int STEP_W     = 16;
    localparam int FRAC_SHIFT = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;

    // right - 2*mid + left, coef * d, then the shifted and summed forms
    localparam int D_W   = SAMPLE_W + 2;
    localparam int P_W   = D_W + COEF_W + 1;
    localparam int SH_W  = P_W - FRAC_SHIFT;
    localparam int SUM_W = SH_W + 1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    localparam logic [COEF_W-1:0] COEF_RST  = COEF_W'(655);
    localparam logic [STEP_W-1:0] STEPS_RST = STEP_W'(10000);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_COEF  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_STEPS = t_cfg_idx'(1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_STEP,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic [IDX_W-1:0]           index;
        logic                       end_of_grid;
    } t_out;

    // tag riding along with a registered memory read
    typedef struct packed {
        logic              vld;
        logic              emit;
        logic [ADDR_W-1:0] pos;
    } t_tag;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic [CNT_W-1:0]  n;
        logic              ends_zero;
        logic              ld_we;
        logic [ADDR_W-1:0] ld_addr;
    } t_ctrl;

    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] data;
    } t_wr;

endpackage

`default_nettype wire

>>> hw/rtl/heat_equation_1d_stepper.sv
// ----------------------------------------------------------------------------
// heat_equation_1d_stepper
// Explicit 1-D heat equation stepper on a fixed-point grid of up to 64 nodes.
// ----------------------------------------------------------------------------
// Samples load at one per cycle while busy is low; samples past 64 nodes are
// dropped. The word with last set closes the load and raises busy. With n
// nodes (n >= 3) and a nonzero step count, each time step is one sweep of
// the grid through a single shared multiply unit, one node per cycle off the
// one read port of the node memory, plus a pipeline drain. The grid is then
// emitted one node per cycle on o_result with o_result_vld; results cannot be
// held off and must be taken in the cycle they appear.
`default_nettype none

module heat_equation_1d_stepper import he1d_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire t_in                  i_item,
    output logic                      o_result_vld,
    output t_out                      o_result,
    input  wire logic                 i_cfg_we,
    input  wire t_cfg_idx             i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    logic [COEF_W-1:0]          r_coef;
    logic [STEP_W-1:0]          r_steps;
    t_ctrl                      ctrl;
    t_tag                       tag;
    t_wr                        alu_wr;
    logic                       alu_busy;
    logic [SAMPLE_W-1:0]        rdata;
    logic signed [SAMPLE_W-1:0] rd_value;
    logic                       is_end_node, is_last_node;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef  <= COEF_RST;
            r_steps <= STEPS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COEF:  r_coef  <= i_cfg_data[COEF_W-1:0];
                CFG_STEPS: r_steps <= i_cfg_data[STEP_W-1:0];
                default:   r_coef  <= r_coef;
            endcase
        end
    end

    he1d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_last     (i_item.last),
        .i_steps    (r_steps),
        .i_alu_busy (alu_busy),
        .o_busy     (busy),
        .o_ctrl     (ctrl),
        .o_tag      (tag)
    );

    he1d_grid_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (ctrl.ld_we | alu_wr.en),
        .i_waddr (ctrl.ld_we ? ctrl.ld_addr : alu_wr.addr),
        .i_wdata (ctrl.ld_we ? i_item.sample : alu_wr.data),
        .i_re    (ctrl.rd_en),
        .i_raddr (ctrl.rd_addr),
        .o_rdata (rdata)
    );

    // end nodes read as zero once the first step has finished
    assign is_last_node = CNT_W'(tag.pos) == ctrl.n - CNT_W'(1);
    assign is_end_node  = (tag.pos == '0) || is_last_node;
    assign rd_value     = (ctrl.ends_zero && is_end_node) ? '0 : rdata;

    he1d_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (r_coef),
        .i_tag   (tag),
        .i_value (rd_value),
        .o_wr    (alu_wr),
        .o_busy  (alu_busy)
    );

    assign o_result_vld         = tag.vld && tag.emit;
    assign o_result.value       = rd_value;
    assign o_result.index       = IDX_W'(tag.pos);
    assign o_result.end_of_grid = is_last_node;

endmodule

`default_nettype wire

>>> hw/rtl/he1d_grid_mem.sv
// ----------------------------------------------------------------------------
// he1d_grid_mem
// Node memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module he1d_grid_mem import he1d_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [ADDR_W-1:0]   i_waddr,
    input  wire logic [SAMPLE_W-1:0] i_wdata,
    input  wire logic                i_re,
    input  wire logic [ADDR_W-1:0]   i_raddr,
    output logic      [SAMPLE_W-1:0] o_rdata
);

    logic [SAMPLE_W-1:0] r_mem [MAX_POINTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/he1d_alu.sv
// ----------------------------------------------------------------------------
// he1d_alu
// Shared node update unit: three-node window, multiply, shift and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module he1d_alu import he1d_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [COEF_W-1:0]          i_coef,
    input  wire t_tag                       i_tag,
    input  wire logic signed [SAMPLE_W-1:0] i_value,
    output t_wr                             o_wr,
    output logic                            o_busy
);

    logic signed [SAMPLE_W-1:0] r_left, r_mid;
    logic                       r_s1_vld, r_s2_vld;
    logic signed [D_W-1:0]      r_s1_d, n_s1_d;
    logic signed [SAMPLE_W-1:0] r_s1_mid, r_s2_mid;
    logic [ADDR_W-1:0]          r_s1_addr, r_s2_addr;
    logic signed [P_W-1:0]      r_s2_prod, n_s2_prod;
    logic signed [SH_W-1:0]     shifted;
    logic signed [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0]        sat;
    logic                       win_shift, n_s1_vld;

    assign win_shift = i_tag.vld && !i_tag.emit;
    // a full window exists once the third node of the sweep arrives
    assign n_s1_vld  = win_shift && (i_tag.pos >= ADDR_W'(2));
    assign n_s1_d    = D_W'(i_value) + D_W'(r_left) - (D_W'(r_mid) <<< 1);
    assign n_s2_prod = $signed({1'b0, i_coef}) * r_s1_d;

    // arithmetic shift is a floor divide by 2^16
    assign shifted = r_s2_prod[P_W-1:FRAC_SHIFT];
    assign sum     = SUM_W'(r_s2_mid) + SUM_W'(shifted);

    always_comb begin
        if (sum > SUM_W'(SAMPLE_MAX)) begin
            sat = SAMPLE_MAX;
        end else if (sum < SUM_W'(SAMPLE_MIN)) begin
            sat = SAMPLE_MIN;
        end else begin
            sat = sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (win_shift) begin
            r_left <= r_mid;
            r_mid  <= i_value;
        end
        r_s1_d    <= n_s1_d;
        r_s1_mid  <= r_mid;
        r_s1_addr <= i_tag.pos - ADDR_W'(1);
        r_s2_prod <= n_s2_prod;
        r_s2_mid  <= r_s1_mid;
        r_s2_addr <= r_s1_addr;
    end

    assign o_wr.en   = r_s2_vld;
    assign o_wr.addr = r_s2_addr;
    assign o_wr.data = sat;
    assign o_busy    = r_s1_vld | r_s2_vld;

endmodule

`default_nettype wire

>>> hw/rtl/he1d_ctrl.sv
// ----------------------------------------------------------------------------
// he1d_ctrl
// Sequencer: load, step sweeps with drain, and grid emission.
// ----------------------------------------------------------------------------
`default_nettype none

module he1d_ctrl import he1d_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_last,
    input  wire logic [STEP_W-1:0] i_steps,
    input  wire logic              i_alu_busy,
    output logic                   o_busy,
    output t_ctrl                  o_ctrl,
    output t_tag                   o_tag
);

    `include "heat_equation_1d_stepper_assert.svh"

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, r_n, r_pos, n_after;
    logic [STEP_W-1:0]  r_step;
    logic               r_ends_zero;
    t_tag               r_tag;
    logic               acc, acc_last, room, sweep_end, drain_done, last_step;

    assign acc        = i_start && (r_state == ST_LOAD);
    assign acc_last   = acc && i_last;
    assign room       = r_cnt < CNT_W'(MAX_POINTS);
    assign n_after    = r_cnt + CNT_W'(room);
    assign sweep_end  = r_pos == r_n - CNT_W'(1);
    assign drain_done = !r_tag.vld && !i_alu_busy;
    assign last_step  = ({1'b0, r_step} + (STEP_W+1)'(1)) == {1'b0, i_steps};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (acc_last) begin
                    if (n_after >= CNT_W'(MIN_STEP_POINTS) && i_steps != '0) begin
                        n_state = ST_STEP;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_STEP: begin
                if (sweep_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_done) begin
                    n_state = last_step ? ST_EMIT : ST_STEP;
                end
            end
            ST_EMIT: begin
                if (sweep_end) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_busy            = 1'b1;
        o_ctrl.rd_en      = 1'b0;
        o_ctrl.rd_addr    = r_pos[ADDR_W-1:0];
        o_ctrl.n          = r_n;
        o_ctrl.ends_zero  = r_ends_zero;
        o_ctrl.ld_we      = 1'b0;
        o_ctrl.ld_addr    = r_cnt[ADDR_W-1:0];
        case (r_state)
            ST_LOAD: begin
                o_busy       = 1'b0;
                o_ctrl.ld_we = acc && room;
            end
            ST_STEP:  o_ctrl.rd_en = 1'b1;
            ST_DRAIN: o_ctrl.rd_en = 1'b0;
            ST_EMIT:  o_ctrl.rd_en = 1'b1;
            default:  o_busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_cnt       <= '0;
            r_n         <= '0;
            r_pos       <= '0;
            r_step      <= '0;
            r_ends_zero <= 1'b0;
            r_tag       <= '0;
        end else begin
            r_state   <= n_state;
            r_tag.vld <= o_ctrl.rd_en;
            r_tag.emit <= (r_state == ST_EMIT);
            r_tag.pos <= r_pos[ADDR_W-1:0];
            if (acc_last) begin
                r_cnt       <= '0;
                r_n         <= n_after;
                r_step      <= '0;
                r_ends_zero <= 1'b0;
                r_pos       <= '0;
            end else if (acc) begin
                r_cnt <= n_after;
            end
            if (r_state == ST_STEP || r_state == ST_EMIT) begin
                r_pos <= sweep_end ? '0 : r_pos + CNT_W'(1);
            end
            if (r_state == ST_DRAIN && drain_done) begin
                r_ends_zero <= 1'b1;
                r_step      <= r_step + STEP_W'(1);
            end
        end
    end

    assign o_tag = r_tag;

    `HE1D_ASSERT_IMPLY(a_pos_in_grid, i_clk, i_rst_n,
        (r_state == ST_STEP || r_state == ST_EMIT), (r_pos < r_n))
    `HE1D_ASSERT_IMPLY(a_step_needs_three, i_clk, i_rst_n,
        (r_state == ST_STEP), (r_n >= CNT_W'(MIN_STEP_POINTS)))
    `HE1D_ASSERT_IMPLY(a_first_step_ends, i_clk, i_rst_n,
        (r_state == ST_STEP && r_step == '0), !r_ends_zero)
    `HE1D_ASSERT_IMPLY(a_alu_quiet, i_clk, i_rst_n,
        (r_state == ST_LOAD || r_state == ST_EMIT), !i_alu_busy)
    `HE1D_ASSERT_NEXT(a_drain_exit_clean, i_clk, i_rst_n,
        (r_state == ST_DRAIN && drain_done), !i_alu_busy)

endmodule

`default_nettype wire
